// ----- rtl/bgd_pkg.sv -----
// ----------------------------------------------------------------------------
// bgd_pkg: button gesture detector package
// Shared types, register indexes and reset values for the gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 8;
  localparam int EVENT_W   = 3;
  localparam int STATE_W   = 4;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST   = 16'd25;
  localparam logic [TICK_W-1:0] HOLD_RST       = 16'd350;
  localparam logic [TICK_W-1:0] DOUBLE_GAP_RST = 16'd200;
  localparam logic [TICK_W-1:0] REPRESS_RST    = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 8'd0,
    REG_HOLD       = 8'd1,
    REG_DOUBLE_GAP = 8'd2,
    REG_REPRESS    = 8'd3
  } reg_idx_t;

  typedef enum logic [STATE_W-1:0] {
    PH_RELEASED              = 4'd0,
    PH_VERIFY_RELEASE        = 4'd1,
    PH_PRESSED               = 4'd2,
    PH_VERIFY_PRESS          = 4'd3,
    PH_DOUBLE_PRESSED        = 4'd4,
    PH_VERIFY_DOUBLE_PRESS   = 4'd5,
    PH_VERIFY_DOUBLE_RELEASE = 4'd6,
    PH_HELD_DOWN             = 4'd7,
    PH_VERIFY_HELD_RELEASE   = 4'd8
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE         = 3'd0,
    EV_CLICK        = 3'd1,
    EV_DOUBLE       = 3'd2,
    EV_HOLD         = 3'd3,
    EV_HOLD_RELEASE = 3'd4
  } event_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] double_gap_ticks;
    logic [TICK_W-1:0] repress_ticks;
  } cfg_t;

endpackage

// ----- rtl/bgd_in_if.sv -----
// ----------------------------------------------------------------------------
// bgd_in_if: tick input channel
// Valid/ready channel carrying one sampled button level per request.
// ----------------------------------------------------------------------------
interface bgd_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

// ----- rtl/bgd_out_if.sv -----
// ----------------------------------------------------------------------------
// bgd_out_if: gesture result channel
// Valid/ready channel carrying the event code and gesture state per tick.
// ----------------------------------------------------------------------------
interface bgd_out_if;
  logic                         valid;
  logic                         ready;
  logic [bgd_pkg::EVENT_W-1:0]  event_code;
  logic [bgd_pkg::STATE_W-1:0]  gesture_state;

  modport source (output valid, output event_code, output gesture_state, input ready);
  modport sink   (input valid, input event_code, input gesture_state, output ready);
endinterface

// ----- rtl/bgd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bgd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bgd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bgd_pkg::CFG_IDX_W-1:0]  index;
  logic [bgd_pkg::TICK_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bgd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bgd_cfg_regs: timeout registers
// Holds the four timeout registers; out-of-range indexes are ignored.
// ----------------------------------------------------------------------------
module bgd_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  bgd_cfg_if.sink        cfg_ch,
  output bgd_pkg::cfg_t  cfg
);

  bgd_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= bgd_pkg::DEBOUNCE_RST;
      cfg_r.hold_ticks       <= bgd_pkg::HOLD_RST;
      cfg_r.double_gap_ticks <= bgd_pkg::DOUBLE_GAP_RST;
      cfg_r.repress_ticks    <= bgd_pkg::REPRESS_RST;
    end else if (wr_en) begin
      unique case (cfg_ch.index)
        bgd_pkg::REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_ch.data;
        bgd_pkg::REG_HOLD:       cfg_r.hold_ticks       <= cfg_ch.data;
        bgd_pkg::REG_DOUBLE_GAP: cfg_r.double_gap_ticks <= cfg_ch.data;
        bgd_pkg::REG_REPRESS:    cfg_r.repress_ticks    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/bgd_core.sv -----
// ----------------------------------------------------------------------------
// bgd_core: gesture state machine and one-shot timer
// Advances the phase and tick timer by one tick whenever step is high.
// ----------------------------------------------------------------------------
module bgd_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bgd_pkg::cfg_t          cfg,
  input  logic                   step,
  input  logic                   level,
  output bgd_pkg::event_t        event_code,
  output bgd_pkg::phase_t        phase_after
);

  bgd_pkg::phase_t              phase_r, phase_nxt;
  logic [bgd_pkg::TICK_W-1:0]   ticks_r, ticks_nxt, ticks_run;
  logic                         run_r, run_nxt, run_after_timer;
  logic                         passed;

  // timer runs first; passed is seen before this tick's transitions
  always_comb begin
    passed          = 1'b0;
    run_after_timer = run_r;
    ticks_run       = ticks_r;
    if (run_r) begin
      if (ticks_r <= 16'd1) begin
        passed          = 1'b1;
        run_after_timer = 1'b0;
        ticks_run       = '0;
      end else begin
        ticks_run = ticks_r - 16'd1;
      end
    end
  end

  // next state: arm loads the timer, halt stops and clears it
  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_run;
    run_nxt   = run_after_timer;
    unique case (phase_r)
      bgd_pkg::PH_RELEASED: begin
        if (level) begin
          ticks_nxt = cfg.debounce_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_VERIFY_PRESS;
        end
      end
      bgd_pkg::PH_VERIFY_RELEASE: begin
        if (level) begin
          ticks_nxt = cfg.debounce_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_VERIFY_DOUBLE_PRESS;
        end else if (passed) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_RELEASED;
        end
      end
      bgd_pkg::PH_VERIFY_PRESS: begin
        if (!level) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_RELEASED;
        end else if (passed) begin
          ticks_nxt = cfg.hold_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_PRESSED;
        end
      end
      bgd_pkg::PH_PRESSED, bgd_pkg::PH_DOUBLE_PRESSED: begin
        if (!level) begin
          run_nxt = 1'b1;
          if (phase_r == bgd_pkg::PH_PRESSED) begin
            ticks_nxt = cfg.double_gap_ticks;
            phase_nxt = bgd_pkg::PH_VERIFY_RELEASE;
          end else begin
            ticks_nxt = cfg.debounce_ticks;
            phase_nxt = bgd_pkg::PH_VERIFY_DOUBLE_RELEASE;
          end
        end else if (passed) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_HELD_DOWN;
        end
      end
      bgd_pkg::PH_VERIFY_DOUBLE_PRESS: begin
        if (!level) begin
          ticks_nxt = cfg.double_gap_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_VERIFY_RELEASE;
        end else if (passed) begin
          ticks_nxt = cfg.hold_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_DOUBLE_PRESSED;
        end
      end
      bgd_pkg::PH_VERIFY_DOUBLE_RELEASE: begin
        if (level) begin
          ticks_nxt = cfg.repress_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_DOUBLE_PRESSED;
        end else if (passed) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_RELEASED;
        end
      end
      bgd_pkg::PH_HELD_DOWN: begin
        if (!level) begin
          ticks_nxt = cfg.debounce_ticks; run_nxt = 1'b1;
          phase_nxt = bgd_pkg::PH_VERIFY_HELD_RELEASE;
        end
      end
      bgd_pkg::PH_VERIFY_HELD_RELEASE: begin
        if (level) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_HELD_DOWN;
        end else if (passed) begin
          ticks_nxt = '0; run_nxt = 1'b0;
          phase_nxt = bgd_pkg::PH_RELEASED;
        end
      end
      default: ;
    endcase
  end

  // event raised on this tick
  always_comb begin
    event_code = bgd_pkg::EV_NONE;
    unique case (phase_r)
      bgd_pkg::PH_VERIFY_RELEASE:
        if (!level && passed) event_code = bgd_pkg::EV_CLICK;
      bgd_pkg::PH_PRESSED, bgd_pkg::PH_DOUBLE_PRESSED:
        if (level && passed) event_code = bgd_pkg::EV_HOLD;
      bgd_pkg::PH_VERIFY_DOUBLE_RELEASE:
        if (!level && passed) event_code = bgd_pkg::EV_DOUBLE;
      bgd_pkg::PH_VERIFY_HELD_RELEASE:
        if (!level && passed) event_code = bgd_pkg::EV_HOLD_RELEASE;
      default: ;
    endcase
  end

  assign phase_after = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bgd_pkg::PH_RELEASED;
      ticks_r <= '0;
      run_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      run_r   <= run_nxt;
    end
  end

  // a stopped timer always holds zero
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> ticks_r == '0)
    else $error("stopped timer holds a nonzero count");

  // released stays released while the button stays up
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == bgd_pkg::PH_RELEASED && !level |=> phase_r == bgd_pkg::PH_RELEASED)
    else $error("left released state without a press");

  // a running timer with time left counts down by exactly one when nothing re-arms it
  a_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    step && run_r && ticks_r > 16'd1 && phase_nxt == phase_r
      |=> ticks_r == $past(ticks_r) - 16'd1)
    else $error("timer did not count down");

endmodule

// ----- rtl/button_gesture_detector.sv -----
// ----------------------------------------------------------------------------
// button_gesture_detector: click, double click, hold and hold release
// Each input request is registered in the input reg, and its result in the result reg.
// Takes one tick per cycle while the sink takes results; a stalled result register holds the input stage.
// A full result register does not block input while the sink takes it.
// Reset (synchronous, rst_n low): released state, timer stopped, timeouts
// back to 25/350/200/1000 ticks, both pipeline registers empty.
// ----------------------------------------------------------------------------
module button_gesture_detector (
  input  logic       clk,
  input  logic       rst_n,
  bgd_in_if.sink     in_ch,
  bgd_out_if.source  out_ch,
  bgd_cfg_if.sink    cfg_ch
);

  bgd_pkg::cfg_t    cfg;
  bgd_pkg::event_t  core_event;
  bgd_pkg::phase_t  core_phase;

  logic                         s1_valid_r;
  logic                         s1_level_r;
  logic                         out_valid_r;
  logic [bgd_pkg::EVENT_W-1:0]  out_event_r;
  logic [bgd_pkg::STATE_W-1:0]  out_state_r;
  logic                         advance;
  logic                         step;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  bgd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bgd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .step        (step),
    .level       (s1_level_r),
    .event_code  (core_event),
    .phase_after (core_phase)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_level_r <= in_ch.button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event_r <= core_event;
      out_state_r <= core_phase;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_code    = out_event_r;
  assign out_ch.gesture_state = out_state_r;

  // events only land in released or held down
  a_event_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r != bgd_pkg::EV_NONE
      |-> out_state_r == bgd_pkg::PH_RELEASED || out_state_r == bgd_pkg::PH_HELD_DOWN)
    else $error("event raised outside released or held down");

  // a held input tick is kept while the result stage is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_level_r))
    else $error("input stage dropped a tick under stall");

  // the core only steps when the result stage can take the result
  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !out_valid_r || out_ch.ready)
    else $error("core stepped into a full result stage");

endmodule
